@@ hw/rtl/lcg48_pkg.sv @@
package lcg48_pkg;

  // State word and register widths
  localparam int STATE_W = 48;
  localparam int REG_W   = 48;
  localparam int HALF_W  = (STATE_W + 1) / 2;
  localparam int PROD_W  = 2 * HALF_W;

  // Transaction payload widths
  localparam int CMD_W    = 2;
  localparam int SEED_W   = 64;
  localparam int BCNT_W   = 6;
  localparam int BOUND_W  = 31;
  localparam int VALUE_W  = 64;
  localparam int WORD_W   = 32;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INCR = 1'b1;

  localparam logic [REG_W-1:0] MULT_RESET = 48'h0005_DEEC_E66D;
  localparam logic [REG_W-1:0] INCR_RESET = 48'h0000_0000_000B;

  // Commands
  localparam logic [CMD_W-1:0] CMD_RESEED = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BOUND  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WIDE   = 2'd3;

  // Rejection loop limit and divider length
  localparam int MAX_DRAWS = 65536;
  localparam int TRY_W     = $clog2(MAX_DRAWS);
  localparam int DIV_STEPS = BOUND_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Partial product select
  localparam logic [1:0] MSEL_LL = 2'd0;
  localparam logic [1:0] MSEL_LH = 2'd1;
  localparam logic [1:0] MSEL_HL = 2'd2;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_INIT   = 2'd1;
  localparam logic [1:0] ACC_ADD_LO = 2'd2;
  localparam logic [1:0] ACC_ADD_HI = 2'd3;

  // State word operations
  localparam logic [1:0] ST_HOLD = 2'd0;
  localparam logic [1:0] ST_SEED = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;

  // Result selection
  localparam logic [2:0] RES_ZERO = 3'd0;
  localparam logic [2:0] RES_RAW  = 3'd1;
  localparam logic [2:0] RES_POW2 = 3'd2;
  localparam logic [2:0] RES_MOD  = 3'd3;
  localparam logic [2:0] RES_WIDE = 3'd4;

  typedef struct packed {
    logic       take;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic [1:0] state_op;
    logic       hi_ld;
    logic       div_init;
    logic       div_step;
    logic       out_ld;
    logic [2:0] res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic pow2;
    logic accept;
  } dp_stat_t;

endpackage

@@ hw/rtl/lcg48_in_if.sv @@
interface lcg48_in_if;
  import lcg48_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [SEED_W-1:0]  seed_word;
  logic [BCNT_W-1:0]         bit_count;
  logic [BOUND_W-1:0]        upper_bound;

  modport source (output valid, cmd, seed_word, bit_count, upper_bound, input ready);
  modport sink (input valid, cmd, seed_word, bit_count, upper_bound, output ready);
endinterface

@@ hw/rtl/lcg48_out_if.sv @@
interface lcg48_out_if;
  import lcg48_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

@@ hw/rtl/lcg48_dp.sv @@
module lcg48_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lcg48_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcg48_pkg::REG_W-1:0]        cfg_wdata,
  input  logic [lcg48_pkg::SEED_W-1:0]       seed_word,
  input  logic [lcg48_pkg::BCNT_W-1:0]       bit_count,
  input  logic [lcg48_pkg::BOUND_W-1:0]      upper_bound,
  input  lcg48_pkg::dp_cmd_t                 cmd,
  output lcg48_pkg::dp_stat_t                stat,
  output logic [lcg48_pkg::VALUE_W-1:0]      value
);
  import lcg48_pkg::*;

  logic [REG_W-1:0]    mult_r, incr_r;
  logic [STATE_W-1:0]  state_r, state_nxt;
  logic [STATE_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [BCNT_W-1:0]   bcnt_r;
  logic [BOUND_W-1:0]  bound_r;
  logic [WORD_W-1:0]   hi_r;
  logic [WORD_W-1:0]   rem_r;
  logic [BOUND_W-1:0]  dvd_r;
  logic [VALUE_W-1:0]  value_r, value_nxt;

  logic [STATE_W-1:0]  mult_s;
  logic [HALF_W-1:0]   op_a, op_b;
  logic [WORD_W-1:0]   top32;
  logic [BOUND_W-1:0]  top31;
  logic [WORD_W-1:0]   rem_sh;
  logic                rem_ge;
  logic [WORD_W:0]     rej_sum;
  logic [4:0]          pow_k;
  logic [4:0]          pow_sh;
  logic [BCNT_W-1:0]   bc_clamp;
  logic [BCNT_W-1:0]   raw_sh;
  logic [WORD_W-1:0]   raw32;

  assign mult_s = STATE_W'(mult_r);
  assign top32  = state_r[STATE_W-1 -: WORD_W];
  assign top31  = state_r[STATE_W-1 -: BOUND_W];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MULT_RESET;
      incr_r <= INCR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MULT: mult_r <= cfg_wdata;
        REG_INCR: incr_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Partial product operand selection; the high-by-high product is never selected, as it lies above the state width
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_LL: begin
        op_a = state_r[HALF_W-1:0];
        op_b = mult_s[HALF_W-1:0];
      end
      MSEL_LH: begin
        op_a = state_r[HALF_W-1:0];
        op_b = HALF_W'(mult_s[STATE_W-1:HALF_W]);
      end
      MSEL_HL: begin
        op_a = HALF_W'(state_r[STATE_W-1:HALF_W]);
        op_b = mult_s[HALF_W-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Accumulator for the state update, wrapping at the state width
  always_comb begin
    unique case (cmd.acc_op)
      ACC_INIT:   acc_nxt = STATE_W'(incr_r);
      ACC_ADD_LO: acc_nxt = acc_r + STATE_W'(prod_r);
      ACC_ADD_HI: acc_nxt = acc_r + (STATE_W'(prod_r) << HALF_W);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Generator state
  always_comb begin
    unique case (cmd.state_op)
      ST_SEED: state_nxt = STATE_W'(seed_word) ^ mult_s;
      ST_ADV:  state_nxt = acc_r;
      default: state_nxt = state_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_W'(MULT_RESET);
    end else begin
      state_r <= state_nxt;
    end
  end

  // Transaction fields and the first word of a 64-bit draw
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      bcnt_r  <= bit_count;
      bound_r <= upper_bound;
    end
    if (cmd.hi_ld) begin
      hi_r <= top32;
    end
  end

  // Restoring divider, one quotient bit per cycle; only the remainder is kept
  assign rem_sh = {rem_r[WORD_W-2:0], dvd_r[BOUND_W-1]};
  assign rem_ge = rem_sh >= WORD_W'(bound_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      dvd_r <= top31;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_sh - WORD_W'(bound_r)) : rem_sh;
      dvd_r <= {dvd_r[BOUND_W-2:0], 1'b0};
    end
  end

  // Rejection test: draw - remainder + (bound - 1) must stay below 2^31
  assign rej_sum = (WORD_W+1)'(top31) - (WORD_W+1)'(rem_r) + (WORD_W+1)'(bound_r)
                   - (WORD_W+1)'(1);
  assign stat.accept = (rej_sum[WORD_W:BOUND_W] == '0);
  assign stat.pow2   = ((bound_r & (~bound_r + BOUND_W'(1))) == bound_r);

  // Power-of-two bound: the multiply and shift reduce to a right shift
  always_comb begin
    pow_k = '0;
    for (int i = 0; i < BOUND_W; i++) begin
      if (bound_r[i]) begin
        pow_k = pow_k | 5'(i);
      end
    end
  end
  assign pow_sh = 5'(BOUND_W) - pow_k;

  // Raw draw: top bits of the state, count limited to one word
  assign bc_clamp = (bcnt_r > BCNT_W'(WORD_W)) ? BCNT_W'(WORD_W) : bcnt_r;
  assign raw_sh   = BCNT_W'(WORD_W) - bc_clamp;
  assign raw32    = (bc_clamp == '0) ? '0 : (top32 >> raw_sh);

  // Result selection
  always_comb begin
    unique case (cmd.res_sel)
      RES_RAW:  value_nxt = {{(VALUE_W-WORD_W){raw32[WORD_W-1]}}, raw32};
      RES_POW2: value_nxt = VALUE_W'(top31 >> pow_sh);
      RES_MOD:  value_nxt = VALUE_W'(rem_r[BOUND_W-1:0]);
      RES_WIDE: value_nxt = {hi_r, {WORD_W{1'b0}}}
                            + {{(VALUE_W-WORD_W){top32[WORD_W-1]}}, top32};
      default:  value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

@@ hw/rtl/lcg48_ctrl.sv @@
module lcg48_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcg48_pkg::CMD_W-1:0]   in_cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  lcg48_pkg::dp_stat_t           stat,
  output lcg48_pkg::dp_cmd_t            cmd
);
  import lcg48_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_MUL3 = 4'd4;
  localparam logic [3:0] S_ADV  = 4'd5;
  localparam logic [3:0] S_POST = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic              second_r, second_nxt;
  logic [TRY_W-1:0]  tries_r, tries_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [2:0]        res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer: reseed goes straight to the result; draws run the multiply
  // sequence, then post-processing per command
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    second_nxt    = second_r;
    tries_nxt     = tries_r;
    dcnt_nxt      = dcnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = MSEL_LL;
    cmd.acc_op    = ACC_HOLD;
    cmd.state_op  = ST_HOLD;
    cmd.res_sel   = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take   = 1'b1;
          op_nxt     = in_cmd;
          second_nxt = 1'b0;
          tries_nxt  = '0;
          if (in_cmd == CMD_RESEED) begin
            cmd.state_op = ST_SEED;
            res_nxt      = RES_ZERO;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        cmd.mul_sel = MSEL_LL;
        cmd.acc_op  = ACC_INIT;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_sel = MSEL_LH;
        cmd.acc_op  = ACC_ADD_LO;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_sel = MSEL_HL;
        cmd.acc_op  = ACC_ADD_HI;
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = S_ADV;
      end
      S_ADV: begin
        cmd.state_op = ST_ADV;
        state_nxt    = S_POST;
      end
      S_POST: begin
        unique case (op_r)
          CMD_RAW: begin
            res_nxt   = RES_RAW;
            state_nxt = S_DONE;
          end
          CMD_BOUND: begin
            if (stat.pow2) begin
              res_nxt   = RES_POW2;
              state_nxt = S_DONE;
            end else begin
              cmd.div_init = 1'b1;
              dcnt_nxt     = '0;
              state_nxt    = S_DIV;
            end
          end
          CMD_WIDE: begin
            if (second_r) begin
              res_nxt   = RES_WIDE;
              state_nxt = S_DONE;
            end else begin
              cmd.hi_ld  = 1'b1;
              second_nxt = 1'b1;
              state_nxt  = S_MUL0;
            end
          end
          default: begin
            res_nxt   = RES_ZERO;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // Keep the remainder once it is unbiased or the retry budget is spent
        if (stat.accept || (tries_r == TRY_W'(MAX_DRAWS - 1))) begin
          res_nxt   = RES_MOD;
          state_nxt = S_DONE;
        end else begin
          tries_nxt = tries_r + TRY_W'(1);
          state_nxt = S_MUL0;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= CMD_RESEED;
      second_r    <= 1'b0;
      tries_r     <= '0;
      dcnt_r      <= '0;
      res_r       <= RES_ZERO;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      second_r    <= second_nxt;
      tries_r     <= tries_nxt;
      dcnt_r      <= dcnt_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

@@ hw/rtl/lcg48_random_generator.sv @@
// Channel   Direction  Payload
// in_ch     sink       cmd, seed_word, bit_count, upper_bound
// out_ch    source     value
// cfg_*     write      cfg_index selects multiplier (0) or increment (1)
//
// A reseed goes straight to the done state; the result is then valid in the
// output register in the same cycle as the next transaction can be accepted.
// Each state advance runs the shared half-width multiplier sequence through
// the states MUL0 to MUL3 and ADV, so a raw or power-of-two draw takes one
// advance and a 64-bit draw two. A bounded draw with any other bound adds the
// bit-serial remainder on every try; every retry takes another state advance.
// A new transaction is accepted only once the previous result sits in the
// output register; a stalled output holds the finished result there.
// Synchronous reset restores both registers and the default seeded state.
module lcg48_random_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lcg48_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcg48_pkg::REG_W-1:0]      cfg_wdata,
  lcg48_in_if.sink                         in_ch,
  lcg48_out_if.source                      out_ch
);
  import lcg48_pkg::*;

  dp_cmd_t             dp_cmd;
  dp_stat_t            dp_stat;
  logic [VALUE_W-1:0]  value;

  // Sequencer
  lcg48_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Arithmetic and state
  lcg48_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .seed_word   (in_ch.seed_word),
    .bit_count   (in_ch.bit_count),
    .upper_bound (in_ch.upper_bound),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .value       (value)
  );

  assign out_ch.value = value;

endmodule

@@ sim/tb.sv @@
module tb;
  import lcg48_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int MAX_REPORTS     = 10;
  // A bounded draw that keeps rejecting runs 65536 tries.
  localparam int WATCHDOG_LIMIT  = 10_000_000;
  localparam int SETTLE_CYCLES   = 40;
  // Random bounded draws that would reject this often get a power-of-two bound.
  localparam int MAX_RANDOM_TRIES = 64;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SEED_W-1:0]  seed_word;
    logic [BCNT_W-1:0]  bit_count;
    logic [BOUND_W-1:0] upper_bound;
  } rng_cmd_t;

  // Tracks the generator state and holds the values that the block must return.
  class draw_scoreboard;
    bit [REG_W-1:0]   multiplier;
    bit [REG_W-1:0]   increment;
    bit [STATE_W-1:0] lcg_word;
    bit [VALUE_W-1:0] expected_values[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      cmd_counts[4];

    function new();
      multiplier = MULT_RESET;
      increment  = INCR_RESET;
      lcg_word   = MULT_RESET;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, bit [REG_W-1:0] val);
      if (idx == REG_MULT) begin
        multiplier = val;
      end else begin
        increment = val;
      end
    endfunction

    // Advances the state once and returns its top bits as a sign-extended word.
    function bit [VALUE_W-1:0] next_bits(int unsigned nbits);
      bit [STATE_W-1:0] top;
      lcg_word = lcg_word * multiplier + increment;
      if (nbits == 0) return '0;
      if (nbits > WORD_W) nbits = WORD_W;
      top = lcg_word >> (STATE_W - nbits);
      return {{(VALUE_W - WORD_W){top[WORD_W-1]}}, top[WORD_W-1:0]};
    endfunction

    // Uniform draw below the bound; tries counts the state advances used.
    function bit [VALUE_W-1:0] bounded_value(bit [BOUND_W-1:0] bound,
                                             output int unsigned tries);
      bit [63:0] n;
      bit [63:0] draw;
      bit [63:0] rem;
      n = 64'(bound);
      tries = 0;
      rem = '0;
      // A zero or power-of-two bound scales one draw.
      if ((n & ((~n + 64'd1) & 64'h7FFF_FFFF)) == n) begin
        tries = 1;
        return (n * next_bits(31)) >> 31;
      end
      // Other bounds redraw while the draw falls in the uneven top range.
      while (tries < MAX_DRAWS) begin
        draw = next_bits(31);
        rem = draw % n;
        tries++;
        if (draw - rem + (n - 64'd1) < 64'h8000_0000) break;
      end
      return rem;
    endfunction

    function int unsigned tries_needed(bit [BOUND_W-1:0] bound);
      bit [STATE_W-1:0] saved;
      int unsigned tries;
      saved = lcg_word;
      void'(bounded_value(bound, tries));
      lcg_word = saved;
      return tries;
    endfunction

    function void note_command(rng_cmd_t c);
      bit [VALUE_W-1:0] hi;
      bit [VALUE_W-1:0] lo;
      bit [VALUE_W-1:0] result;
      int unsigned tries;
      result = '0;
      cmd_counts[c.cmd]++;
      case (c.cmd)
        CMD_RESEED: lcg_word = c.seed_word[STATE_W-1:0] ^ multiplier;
        CMD_RAW:    result = next_bits(c.bit_count);
        CMD_BOUND:  result = bounded_value(c.upper_bound, tries);
        CMD_WIDE: begin
          hi = next_bits(WORD_W);
          lo = next_bits(WORD_W);
          result = (hi << WORD_W) + lo;
        end
        default: ;
      endcase
      expected_values.push_back(result);
    endfunction

    function void check_value(bit [VALUE_W-1:0] got);
      bit [VALUE_W-1:0] want;
      checked++;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Result %h arrived with no transaction outstanding", got);
        return;
      end
      want = expected_values.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Mismatch on result %0d: value expected %h, actual %h",
                   checked, want, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;
  int unsigned          sender_idle_pct;
  int unsigned          receiver_stall_pct;
  int unsigned          quiet_cycles;
  draw_scoreboard       sb = new();

  lcg48_in_if  in_ch ();
  lcg48_out_if out_ch ();

  lcg48_random_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random with the current phase's rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_value(out_ch.value);
  end

  // The run ends if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic rng_cmd_t make_command(logic [CMD_W-1:0] cmd, logic [SEED_W-1:0] seed,
                                            logic [BCNT_W-1:0] bcnt,
                                            logic [BOUND_W-1:0] bound);
    rng_cmd_t c;
    c.cmd         = cmd;
    c.seed_word   = seed;
    c.bit_count   = bcnt;
    c.upper_bound = bound;
    return c;
  endfunction

  function automatic bit [REG_W-1:0] random_reg();
    bit [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[REG_W-1:0];
  endfunction

  // Random command with every field randomized and the used one shaped.
  function automatic rng_cmd_t random_command();
    rng_cmd_t c;
    bit [31:0] r;
    int unsigned pick;
    c.seed_word = {$urandom, $urandom};
    pick = $urandom_range(9);
    if (pick < 6) begin
      c.bit_count = BCNT_W'($urandom_range(32, 1));
    end else if (pick == 6) begin
      c.bit_count = '0;
    end else begin
      c.bit_count = BCNT_W'($urandom_range(63, 33));
    end
    r = $urandom;
    case ($urandom_range(5))
      0: c.upper_bound = BOUND_W'($urandom_range(16));
      1: c.upper_bound = 31'd1 << $urandom_range(30);
      2: c.upper_bound = r[BOUND_W-1:0] | 31'h4000_0000;
      3: c.upper_bound = BOUND_W'($urandom_range(1000, 1));
      default: c.upper_bound = r[BOUND_W-1:0];
    endcase
    pick = $urandom_range(99);
    if (pick < 12) begin
      c.cmd = CMD_RESEED;
    end else if (pick < 40) begin
      c.cmd = CMD_RAW;
    end else if (pick < 75) begin
      c.cmd = CMD_BOUND;
    end else begin
      c.cmd = CMD_WIDE;
    end
    if (c.cmd == CMD_BOUND && sb.tries_needed(c.upper_bound) > MAX_RANDOM_TRIES)
      c.upper_bound = 31'd1 << $urandom_range(30);
    return c;
  endfunction

  // Presents one command transaction, after a random idle gap, until accepted.
  task automatic send_command(rng_cmd_t c);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c.cmd;
    in_ch.seed_word   <= c.seed_word;
    in_ch.bit_count   <= c.bit_count;
    in_ch.upper_bound <= c.upper_bound;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic program_registers(bit [REG_W-1:0] mult, bit [REG_W-1:0] incr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MULT;
    cfg_wdata <= mult;
    sb.set_register(REG_MULT, mult);
    @(posedge clk);
    cfg_index <= REG_INCR;
    cfg_wdata <= incr;
    sb.set_register(REG_INCR, incr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rng_cmd_t         directed[$];
    bit [REG_W-1:0]   mult_val;
    bit [REG_W-1:0]   incr_val;
    int unsigned      settings;

    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_RESEED;
    in_ch.seed_word    <= '0;
    in_ch.bit_count    <= '0;
    in_ch.upper_bound  <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_MULT;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    settings           = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands from the reset registers: bit count and bound extremes,
    // zero and oversized bit counts, zero bound, and reseeds at the seed extremes.
    directed.push_back(make_command(CMD_RAW, '0, 6'd32, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd1, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd0, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd33, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd63, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd31, '0));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'd0));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'd1));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'd2));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'h4000_0000));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'h7FFF_FFFF));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'd3));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'h4000_0001));
    directed.push_back(make_command(CMD_WIDE, '0, '0, '0));
    directed.push_back(make_command(CMD_RESEED, 64'd0, '0, '0));
    directed.push_back(make_command(CMD_WIDE, '0, '0, '0));
    directed.push_back(make_command(CMD_RESEED, '1, '0, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd32, '0));
    directed.push_back(make_command(CMD_RESEED, 64'h8000_0000_0000_0000, '0, '0));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'd1000));
    directed.push_back(make_command(CMD_RESEED, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0));
    directed.push_back(make_command(CMD_RAW, '0, 6'd17, '0));
    foreach (directed[i]) send_command(directed[i]);
    directed.delete();

    // With a zero multiplier every draw lands on the all-ones increment, so a
    // bound of three rejects on every try and the loop runs to its limit.
    drain_results();
    program_registers('0, '1);
    settings++;
    directed.push_back(make_command(CMD_RAW, '0, 6'd32, '0));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'd3));
    directed.push_back(make_command(CMD_WIDE, '0, '0, '0));
    directed.push_back(make_command(CMD_BOUND, '0, '0, 31'h4000_0000));
    foreach (directed[i]) send_command(directed[i]);

    // Random phases, each with a register setting and idling pattern chosen by its number.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0, 7: begin
          mult_val = MULT_RESET;
          incr_val = INCR_RESET;
        end
        1: begin
          mult_val = '1;
          incr_val = '0;
        end
        3: begin
          mult_val = '0;
          incr_val = '1;
        end
        4: begin
          mult_val = 48'd1;
          incr_val = 48'd1;
        end
        6: begin
          mult_val = 48'h8000_0000_0001;
          incr_val = '1;
        end
        default: begin
          mult_val = random_reg() | 48'd1;
          incr_val = random_reg();
        end
      endcase
      drain_results();
      program_registers(mult_val, incr_val);
      settings++;
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 67;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 67;
        end
        default: begin
          sender_idle_pct    = 24;
          receiver_stall_pct = 24;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_command(random_command());
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d reseeds, %0d raw, %0d bounded and %0d 64-bit draws",
             sb.cmd_counts[CMD_RESEED], sb.cmd_counts[CMD_RAW],
             sb.cmd_counts[CMD_BOUND], sb.cmd_counts[CMD_WIDE]);
    $display("under %0d register settings; %0d results checked, %0d mismatches.",
             settings, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_values.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lcg48_pkg.sv
hw/rtl/lcg48_in_if.sv
hw/rtl/lcg48_out_if.sv
hw/rtl/lcg48_dp.sv
hw/rtl/lcg48_ctrl.sv
hw/rtl/lcg48_random_generator.sv
sim/tb.sv
